### hdl/text_console_writer_macros.svh
// Assertion helpers shared by the console writer modules.
// Both sample on clock and are disabled while reset is high.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, a, c, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, a, c, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) else $error(msg);

`endif

### hdl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int ADDR_W     = 11;
   localparam int POS_W      = 11;
   localparam int DATA_W     = 16;
   localparam int ATTR_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'd7;
   localparam logic [DATA_W-1:0] BLANK_RESET = 16'd1824;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam int                TAB_STOP   = 4;

   localparam logic [OP_W-1:0] OP_PUT       = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
   localparam logic [OP_W-1:0] OP_READ      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK     = 1'd1;

   // store sweep kinds
   localparam logic [1:0] SWEEP_FILL      = 2'd0;
   localparam logic [1:0] SWEEP_BACKSPACE = 2'd1;
   localparam logic [1:0] SWEEP_SCROLL    = 2'd2;

   typedef struct packed {
      logic       load;         // capture request item
      logic       decode;       // apply cursor update, issue put write or read
      logic       sweep_start;
      logic [1:0] sweep_kind;
      logic       sweep_step;
      logic       rsp_load;
   } tcw_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            scroll;
      logic            bs_home;
      logic            sweep_last;
   } tcw_status_type;

endpackage

### hdl/text_console_writer.sv
`timescale 1ns / 1ps

// Text console engine over a ROWS x COLUMNS store of 16-bit cells (character in
// the low byte, attribute in the high byte). Put, read and a backspace at the
// home position go from accept through the decode and response states, the
// result being loaded once the result register is free; the next item is
// taken back in idle. Clear, backspace and any put that scrolls walk the
// store one cell per cycle through its single write port (backspace only from
// the new cursor position to the end). After reset a clearing pass fills the
// store with the blank cell while req_stall stays high; configuration writes
// are taken at any time (csr_ready is always high) but belong in idle periods.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tcw_pkg::OP_W-1:0]       req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]     req_cell_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]      rsp_cursor_pos,
   output logic [tcw_pkg::DATA_W-1:0]     rsp_cell_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_char_code    (req_char_code),
      .req_cell_address (req_cell_address),
      .csr_we           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_cell_data    (rsp_cell_data)
   );

endmodule

### hdl/tcw_ctrl.sv
`timescale 1ns / 1ps

`include "text_console_writer_macros.svh"

module tcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);

   localparam logic [2:0] ST_BOOT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       boot_ff, boot_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      boot_in  = boot_ff;
      cmd      = '0;
      case (state_ff)
         ST_BOOT: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_kind  = tcw_pkg::SWEEP_FILL;
            state_in        = ST_SWEEP;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_RESP;
            case (status.op)
               tcw_pkg::OP_PUT: begin
                  if (status.scroll) begin
                     cmd.sweep_start = 1'b1;
                     cmd.sweep_kind  = tcw_pkg::SWEEP_SCROLL;
                     state_in        = ST_SWEEP;
                  end
               end
               tcw_pkg::OP_BACKSPACE: begin
                  if (!status.bs_home) begin
                     cmd.sweep_start = 1'b1;
                     cmd.sweep_kind  = tcw_pkg::SWEEP_BACKSPACE;
                     state_in        = ST_SWEEP;
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  cmd.sweep_kind  = tcw_pkg::SWEEP_FILL;
                  state_in        = ST_SWEEP;
               end
               default: ;
            endcase
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // last store write lands at the end of this cycle
            boot_in  = 1'b0;
            state_in = boot_ff ? ST_IDLE : ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TCW_ASSERT_NXT(a_accept_decodes, (state_ff == ST_IDLE) && req_valid, state_ff == ST_DECODE, "accepted item not decoded")
   `TCW_ASSERT_IMP(a_rsp_no_overwrite, cmd.rsp_load, !(rsp_valid_ff && rsp_stall), "result register overwritten")
   `TCW_ASSERT_IMP(a_boot_ends_in_drain, $fell(boot_ff), $past(state_ff) == ST_DRAIN, "boot fill ended early")

endmodule

### hdl/tcw_datapath.sv
`timescale 1ns / 1ps

`include "text_console_writer_macros.svh"

module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcw_pkg::tcw_cmd_type           cmd,
   output tcw_pkg::tcw_status_type        status,
   input  logic [tcw_pkg::OP_W-1:0]       req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]     req_cell_address,
   input  logic                           csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [tcw_pkg::POS_W-1:0]      rsp_cursor_pos,
   output logic [tcw_pkg::DATA_W-1:0]     rsp_cell_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int XW    = ((AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W) + 1;
   localparam int DW    = tcw_pkg::DATA_W;

   logic [DW-1:0] mem [CELLS];

   logic [tcw_pkg::OP_W-1:0]   op_ff;
   logic [tcw_pkg::CHAR_W-1:0] char_ff;
   logic [tcw_pkg::ADDR_W-1:0] addr_ff;

   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   logic [DW-1:0]              blank_ff;

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic [AW-1:0] dst_ff;
   logic [1:0]    mode_ff;

   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [DW-1:0] wr_data_ff, wr_data_in;
   logic          wr_from_rd_ff, wr_from_rd_in;
   logic [DW-1:0] rd_q_ff;

   logic [tcw_pkg::POS_W-1:0] cursor_ff;
   logic [DW-1:0]             data_ff;

   logic [AW-1:0]           pos;
   logic [AW+tcw_pkg::POS_W-1:0] pos_ext;
   logic [CW:0]             col_inc;
   logic [CW:0]             tab_stop;
   logic                    wrap;
   logic                    write_char;
   logic [AW:0]             src_wide;
   logic                    copy;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [XW-1:0]           addr_ext;
   logic                    addr_ok;

   assign pos      = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign tab_stop = ({1'b0, col_ff} / (CW+1)'(tcw_pkg::TAB_STOP) + 1'b1)
                     * (CW+1)'(tcw_pkg::TAB_STOP);
   assign addr_ext = XW'(addr_ff);
   assign addr_ok  = addr_ext < XW'(CELLS);

   // next cursor position
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      wrap       = 1'b0;
      write_char = 1'b0;
      case (op_ff)
         tcw_pkg::OP_PUT: begin
            if (char_ff == tcw_pkg::CH_NEWLINE) begin
               wrap = 1'b1;
            end else if (char_ff == tcw_pkg::CH_TAB) begin
               if (tab_stop >= (CW+1)'(COLUMNS)) wrap = 1'b1;
               else col_in = tab_stop[CW-1:0];
            end else begin
               write_char = 1'b1;
               if (col_inc >= (CW+1)'(COLUMNS)) wrap = 1'b1;
               else col_in = col_inc[CW-1:0];
            end
            if (wrap) begin
               col_in = '0;
               // on the last row the row stays and the store scrolls
               if (row_ff != RW'(ROWS-1)) row_in = row_ff + 1'b1;
            end
         end
         tcw_pkg::OP_BACKSPACE: begin
            if (pos != '0) begin
               if (col_ff != '0) begin
                  col_in = col_ff - 1'b1;
               end else begin
                  col_in = CW'(COLUMNS-1);
                  row_in = row_ff - 1'b1;
               end
            end
         end
         tcw_pkg::OP_CLEAR: begin
            row_in = '0;
            col_in = '0;
         end
         default: ;
      endcase
   end

   assign status.op         = op_ff;
   assign status.scroll     = wrap && (row_ff == RW'(ROWS-1));
   assign status.bs_home    = (pos == '0);
   assign status.sweep_last = (dst_ff == AW'(CELLS-1));

   // sweep source: dst+1 for backspace, dst+COLUMNS for scroll, none for fill
   always_comb begin
      case (mode_ff)
         tcw_pkg::SWEEP_BACKSPACE: src_wide = {1'b0, dst_ff} + (AW+1)'(1);
         tcw_pkg::SWEEP_SCROLL:    src_wide = {1'b0, dst_ff} + (AW+1)'(COLUMNS);
         default:                  src_wide = (AW+1)'(CELLS);
      endcase
      copy = src_wide < (AW+1)'(CELLS);
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = src_wide[AW-1:0];
      if (cmd.decode && (op_ff == tcw_pkg::OP_READ)) begin
         rd_en   = 1'b1;
         rd_addr = addr_ext[AW-1:0];
      end else if (cmd.sweep_step && copy) begin
         rd_en = 1'b1;
      end
   end

   always_comb begin
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      wr_from_rd_in = wr_from_rd_ff;
      if (cmd.decode && (op_ff == tcw_pkg::OP_PUT) && write_char) begin
         wr_pend_in    = 1'b1;
         wr_addr_in    = pos;
         wr_data_in    = {attr_ff, char_ff};
         wr_from_rd_in = 1'b0;
      end else if (cmd.sweep_step) begin
         wr_pend_in    = 1'b1;
         wr_addr_in    = dst_ff;
         wr_data_in    = blank_ff;
         wr_from_rd_in = copy;
      end
   end

   // store: one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (rd_en) rd_q_ff <= mem[rd_addr];
      if (wr_pend_ff) mem[wr_addr_ff] <= wr_from_rd_ff ? rd_q_ff : wr_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
         row_ff     <= '0;
         col_ff     <= '0;
         attr_ff    <= tcw_pkg::ATTR_RESET;
         blank_ff   <= tcw_pkg::BLANK_RESET;
      end else begin
         wr_pend_ff <= wr_pend_in;
         if (cmd.decode) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_we) begin
            case (csr_index)
               tcw_pkg::CSR_ATTRIBUTE: attr_ff  <= csr_data[tcw_pkg::ATTR_W-1:0];
               tcw_pkg::CSR_BLANK:     blank_ff <= csr_data[DW-1:0];
               default: ;
            endcase
         end
      end
   end

   assign pos_ext = {{tcw_pkg::POS_W{1'b0}}, pos};

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      wr_from_rd_ff <= wr_from_rd_in;
      if (cmd.load) begin
         op_ff   <= req_op;
         char_ff <= req_char_code;
         addr_ff <= req_cell_address;
      end
      if (cmd.sweep_start) begin
         mode_ff <= cmd.sweep_kind;
         dst_ff  <= (cmd.sweep_kind == tcw_pkg::SWEEP_BACKSPACE) ? pos - 1'b1 : '0;
      end else if (cmd.sweep_step) begin
         dst_ff <= dst_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         cursor_ff <= pos_ext[tcw_pkg::POS_W-1:0];
         data_ff   <= ((op_ff == tcw_pkg::OP_READ) && addr_ok) ? rd_q_ff : '0;
      end
   end

   assign rsp_cursor_pos = cursor_ff;
   assign rsp_cell_data  = data_ff;

   `TCW_ASSERT_IMP(a_write_in_store, wr_pend_ff, wr_addr_ff <= AW'(CELLS-1), "store write out of range")
   `TCW_ASSERT_IMP(a_cursor_in_range, 1'b1, (row_ff <= RW'(ROWS-1)) && (col_ff <= CW'(COLUMNS-1)), "cursor out of range")
   `TCW_ASSERT_IMP(a_sweep_in_store, cmd.sweep_step, dst_ff <= AW'(CELLS-1), "sweep beyond store")

endmodule
